[sv/sdit_pkg.sv]
// Shared constants, codes and control types of the sorted dependency index table.
`timescale 1ns / 1ps
package sdit_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned ID_BITS  = 16;
  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam int unsigned CW       = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 3 * ID_BITS;
  localparam int unsigned ENTRY_W  = 4 * ID_BITS;

  localparam logic [ID_BITS-1:0] INV_ID = {ID_BITS{1'b1}};

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_INVAL  = 2'd1;
  localparam logic [1:0] OP_RETIRE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_NODE   = 2'd1;
  localparam logic [1:0] KIND_REGION = 2'd2;
  localparam logic [1:0] KIND_EMPTY  = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC_SCAN,
    S_REC_SHIFT,
    S_REC_WRITE,
    S_RETIRE,
    S_INV_SCAN,
    S_INV_REG,
    S_FLUSH,
    S_ACK
  } state_e;

  typedef struct packed {
    logic   accept;
    state_e step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rec_bad;
    logic dep_bad;
    logic scan_done;
    logic shift_done;
    logic dup_or_full;
    logic reg_empty;
  } ctrl_stat_t;

endpackage

[sv/sdit_ram.sv]
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module sdit_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/sdit_ctrl.sv]
// Controller state machine sequencing record, invalidate and retire requests.
`timescale 1ns / 1ps
module sdit_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          op_i,
  input  sdit_pkg::ctrl_stat_t stat_i,
  output sdit_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy_o
);

  sdit_pkg::state_e state_q, state_d;
  logic accept;

  assign accept = start_i && (state_q == sdit_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdit_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdit_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            sdit_pkg::OP_RECORD:
              state_d = stat_i.rec_bad ? sdit_pkg::S_ACK : sdit_pkg::S_REC_SCAN;
            sdit_pkg::OP_INVAL:
              state_d = stat_i.dep_bad ? sdit_pkg::S_FLUSH : sdit_pkg::S_INV_SCAN;
            sdit_pkg::OP_RETIRE: state_d = sdit_pkg::S_RETIRE;
            default:             state_d = sdit_pkg::S_ACK;
          endcase
        end
      end
      sdit_pkg::S_REC_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = stat_i.dup_or_full ? sdit_pkg::S_ACK : sdit_pkg::S_REC_SHIFT;
        end
      end
      sdit_pkg::S_REC_SHIFT: begin
        if (stat_i.shift_done) state_d = sdit_pkg::S_REC_WRITE;
      end
      sdit_pkg::S_REC_WRITE: state_d = sdit_pkg::S_ACK;
      sdit_pkg::S_RETIRE: begin
        if (stat_i.scan_done) state_d = sdit_pkg::S_ACK;
      end
      sdit_pkg::S_INV_SCAN: begin
        if (stat_i.scan_done) state_d = sdit_pkg::S_INV_REG;
      end
      sdit_pkg::S_INV_REG: begin
        if (stat_i.reg_empty) state_d = sdit_pkg::S_FLUSH;
      end
      sdit_pkg::S_FLUSH: state_d = sdit_pkg::S_IDLE;
      sdit_pkg::S_ACK:   state_d = sdit_pkg::S_IDLE;
      default:           state_d = sdit_pkg::S_IDLE;
    endcase
  end

  assign cmd_o.accept = accept;
  assign cmd_o.step   = state_q;
  assign busy_o       = (state_q != sdit_pkg::S_IDLE);

endmodule

[sv/sdit_dp.sv]
// Datapath: entry RAM walks, region sort cells, counts and result register.
`timescale 1ns / 1ps
module sdit_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sdit_pkg::ctrl_cmd_t               cmd_i,
  output sdit_pkg::ctrl_stat_t              stat_o,
  input  logic [1:0]                        op_i,
  input  logic [sdit_pkg::ID_BITS-1:0]      dep_id_i,
  input  logic [sdit_pkg::ID_BITS-1:0]      node_id_i,
  input  logic [sdit_pkg::ID_BITS-1:0]      region_id_i,
  input  logic [sdit_pkg::ID_BITS-1:0]      method_id_i,
  output logic                              result_valid_o,
  output logic [1:0]                        kind_o,
  output logic [15:0]                       item_value_o,
  output logic [2:0]                        status_o,
  output logic                              last_o,
  output logic [5:0]                        entry_count_o,
  output logic [5:0]                        distinct_deps_o
);

  localparam int unsigned IB = sdit_pkg::ID_BITS;
  localparam int unsigned AW = sdit_pkg::AW;
  localparam int unsigned CW = sdit_pkg::CW;
  localparam int unsigned N  = sdit_pkg::CAPACITY;

  // request fields
  logic [IB-1:0] dep_q, node_q, reg_q, meth_q;
  // walk state
  logic [CW-1:0] idx_q, idx_d;
  logic          rv_q, rv_d;
  logic [AW-1:0] ri_q, ri_d;
  logic [CW-1:0] pos_q, w_q, cnt_q;
  logic          fge_q, eq_q, depseen_q;
  logic [IB-1:0] pdep_q;
  // table counts
  logic [CW-1:0] held_q, dist_q;
  // invalidate state
  logic          have_node_q, have_reg_q;
  logic [IB-1:0] pnode_q, preg_q;
  logic [IB-1:0] cell_q [N];
  logic [IB-1:0] cell_d [N];
  logic [N-1:0]  gt;
  logic [CW-1:0] nreg_q;
  logic          pend_v_q;
  logic [1:0]    pend_kind_q;
  logic [IB-1:0] pend_val_q;
  logic [2:0]    ack_st_q;
  // result register
  logic          out_v_q;
  logic [1:0]    out_kind_q;
  logic [IB-1:0] out_val_q;
  logic [2:0]    out_st_q;
  logic          out_last_q;

  // RAM port
  logic                          we;
  logic [AW-1:0]                 waddr, raddr;
  logic [sdit_pkg::ENTRY_W-1:0]  wdata, rdata;

  logic [sdit_pkg::KEY_W-1:0] key, e_key;
  logic [IB-1:0] e_dep, e_node, e_reg, e_meth;
  logic          scan_done, shift_done, dep_hit;
  logic          new_v;
  logic [1:0]    new_kind;
  logic [IB-1:0] new_val;
  sdit_pkg::state_e step;

  assign step   = cmd_i.step;
  assign key    = {dep_q, node_q, reg_q};
  assign e_dep  = rdata[4*IB-1:3*IB];
  assign e_node = rdata[3*IB-1:2*IB];
  assign e_reg  = rdata[2*IB-1:IB];
  assign e_meth = rdata[IB-1:0];
  assign e_key  = rdata[4*IB-1:IB];
  assign dep_hit = rv_q && (e_dep == dep_q);

  assign scan_done  = (idx_q >= held_q) && !rv_q;
  assign shift_done = (idx_q == pos_q) && !rv_q;

  assign stat_o.rec_bad     = (dep_id_i == sdit_pkg::INV_ID) ||
                              ((node_id_i == sdit_pkg::INV_ID) &&
                               (region_id_i == sdit_pkg::INV_ID));
  assign stat_o.dep_bad     = (dep_id_i == sdit_pkg::INV_ID);
  assign stat_o.scan_done   = scan_done;
  assign stat_o.shift_done  = shift_done;
  assign stat_o.dup_or_full = eq_q || (held_q == CW'(N));
  assign stat_o.reg_empty   = (nreg_q == '0);

  sdit_ram #(
    .WIDTH(sdit_pkg::ENTRY_W),
    .DEPTH(sdit_pkg::CAPACITY)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Read sequencing and table writes.
  always_comb begin
    idx_d = idx_q;
    rv_d  = 1'b0;
    ri_d  = ri_q;
    raddr = idx_q[AW-1:0];
    we    = 1'b0;
    waddr = ri_q;
    wdata = rdata;
    unique case (step)
      sdit_pkg::S_REC_SCAN, sdit_pkg::S_RETIRE, sdit_pkg::S_INV_SCAN: begin
        if (idx_q < held_q) begin
          idx_d = idx_q + CW'(1);
          rv_d  = 1'b1;
          ri_d  = idx_q[AW-1:0];
        end
        if (step == sdit_pkg::S_RETIRE && rv_q && e_meth != meth_q) begin
          we    = 1'b1;
          waddr = w_q[AW-1:0];
        end
      end
      sdit_pkg::S_REC_SHIFT: begin
        raddr = AW'(idx_q - CW'(1));
        if (idx_q > pos_q) begin
          idx_d = idx_q - CW'(1);
          rv_d  = 1'b1;
          ri_d  = raddr;
        end
        if (rv_q) begin
          we    = 1'b1;
          waddr = ri_q + AW'(1);
        end
      end
      sdit_pkg::S_REC_WRITE: begin
        we    = 1'b1;
        waddr = pos_q[AW-1:0];
        wdata = {key, meth_q};
      end
      default: ;
    endcase
  end

  // Node results come from the scan; regions come out of the sort cells.
  always_comb begin
    new_v    = 1'b0;
    new_kind = sdit_pkg::KIND_NODE;
    new_val  = e_node;
    if (step == sdit_pkg::S_INV_SCAN) begin
      new_v = dep_hit && (e_node != sdit_pkg::INV_ID) &&
              (!have_node_q || e_node != pnode_q);
    end else if (step == sdit_pkg::S_INV_REG) begin
      new_kind = sdit_pkg::KIND_REGION;
      new_val  = cell_q[0];
      new_v    = (nreg_q != '0) && (!have_reg_q || cell_q[0] != preg_q);
    end
  end

  // Sorted insert: cells at or below the new value stay, larger ones move up; in S_INV_REG all shift down by one.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      gt[k] = (CW'(k) < nreg_q) ? (cell_q[k] > e_reg) : 1'b1;
    end
    for (int k = 0; k < N; k++) begin
      cell_d[k] = cell_q[k];
      if (step == sdit_pkg::S_INV_SCAN) begin
        if (gt[k]) begin
          cell_d[k] = (k > 0 && gt[(k > 0) ? k - 1 : 0]) ? cell_q[(k > 0) ? k - 1 : 0]
                                                        : e_reg;
        end
      end else begin
        cell_d[k] = (k < N - 1) ? cell_q[(k < N - 1) ? k + 1 : k] : cell_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step == sdit_pkg::S_INV_SCAN) begin
      if (dep_hit && e_reg != sdit_pkg::INV_ID) cell_q <= cell_d;
    end else if (step == sdit_pkg::S_INV_REG && nreg_q != '0) begin
      cell_q <= cell_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dep_q  <= dep_id_i;
      node_q <= node_id_i;
      reg_q  <= region_id_i;
      meth_q <= method_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rv_q        <= 1'b0;
      ri_q        <= '0;
      pos_q       <= '0;
      w_q         <= '0;
      cnt_q       <= '0;
      fge_q       <= 1'b0;
      eq_q        <= 1'b0;
      depseen_q   <= 1'b0;
      pdep_q      <= '0;
      held_q      <= '0;
      dist_q      <= '0;
      have_node_q <= 1'b0;
      have_reg_q  <= 1'b0;
      pnode_q     <= '0;
      preg_q      <= '0;
      nreg_q      <= '0;
      pend_v_q    <= 1'b0;
      pend_kind_q <= sdit_pkg::KIND_ACK;
      pend_val_q  <= '0;
      ack_st_q    <= sdit_pkg::ST_IGNORED;
      out_v_q     <= 1'b0;
      out_kind_q  <= sdit_pkg::KIND_ACK;
      out_val_q   <= '0;
      out_st_q    <= sdit_pkg::ST_DONE;
      out_last_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      rv_q    <= rv_d;
      ri_q    <= ri_d;
      out_v_q <= 1'b0;

      if (cmd_i.accept) begin
        idx_q       <= '0;
        rv_q        <= 1'b0;
        pos_q       <= held_q;
        w_q         <= '0;
        cnt_q       <= '0;
        fge_q       <= 1'b0;
        eq_q        <= 1'b0;
        depseen_q   <= 1'b0;
        have_node_q <= 1'b0;
        have_reg_q  <= 1'b0;
        nreg_q      <= '0;
        pend_v_q    <= 1'b0;
        if (op_i == sdit_pkg::OP_RECORD) begin
          ack_st_q <= stat_o.rec_bad ? sdit_pkg::ST_IGNORED : sdit_pkg::ST_INSERTED;
        end else if (op_i == sdit_pkg::OP_RETIRE) begin
          ack_st_q <= sdit_pkg::ST_DONE;
        end else begin
          ack_st_q <= sdit_pkg::ST_IGNORED;
        end
      end

      unique case (step)
        sdit_pkg::S_REC_SCAN: begin
          if (rv_q) begin
            if (!fge_q && e_key >= key) begin
              fge_q <= 1'b1;
              pos_q <= CW'(ri_q);
              eq_q  <= (e_key == key);
            end
            if (e_dep == dep_q) depseen_q <= 1'b1;
          end
          if (scan_done) begin
            idx_q <= held_q;
            if (eq_q) ack_st_q <= sdit_pkg::ST_DUP;
            else if (held_q == CW'(N)) ack_st_q <= sdit_pkg::ST_FULL;
          end
        end
        sdit_pkg::S_REC_WRITE: begin
          held_q <= held_q + CW'(1);
          if (!depseen_q) dist_q <= dist_q + CW'(1);
        end
        sdit_pkg::S_RETIRE: begin
          if (rv_q && e_meth != meth_q) begin
            w_q    <= w_q + CW'(1);
            pdep_q <= e_dep;
            if (w_q == '0 || e_dep != pdep_q) cnt_q <= cnt_q + CW'(1);
          end
          if (scan_done) begin
            held_q <= w_q;
            dist_q <= cnt_q;
          end
        end
        sdit_pkg::S_INV_SCAN: begin
          if (new_v) begin
            have_node_q <= 1'b1;
            pnode_q     <= e_node;
          end
          if (dep_hit && e_reg != sdit_pkg::INV_ID) nreg_q <= nreg_q + CW'(1);
        end
        sdit_pkg::S_INV_REG: begin
          if (nreg_q != '0) begin
            nreg_q     <= nreg_q - CW'(1);
            have_reg_q <= 1'b1;
            preg_q     <= cell_q[0];
          end
        end
        sdit_pkg::S_FLUSH: begin
          out_v_q    <= 1'b1;
          out_last_q <= 1'b1;
          out_st_q   <= sdit_pkg::ST_DONE;
          out_kind_q <= pend_v_q ? pend_kind_q : sdit_pkg::KIND_EMPTY;
          out_val_q  <= pend_v_q ? pend_val_q : '0;
          pend_v_q   <= 1'b0;
        end
        sdit_pkg::S_ACK: begin
          out_v_q    <= 1'b1;
          out_last_q <= 1'b1;
          out_st_q   <= ack_st_q;
          out_kind_q <= sdit_pkg::KIND_ACK;
          out_val_q  <= '0;
        end
        default: ;
      endcase

      // one result held back so the final one can carry last
      if (new_v) begin
        pend_v_q    <= 1'b1;
        pend_kind_q <= new_kind;
        pend_val_q  <= new_val;
        if (pend_v_q) begin
          out_v_q    <= 1'b1;
          out_last_q <= 1'b0;
          out_st_q   <= sdit_pkg::ST_DONE;
          out_kind_q <= pend_kind_q;
          out_val_q  <= pend_val_q;
        end
      end
    end
  end

  assign result_valid_o  = out_v_q;
  assign kind_o          = out_kind_q;
  assign item_value_o    = 16'(out_val_q);
  assign status_o        = out_st_q;
  assign last_o          = out_last_q;
  assign entry_count_o   = 6'(held_q);
  assign distinct_deps_o = 6'(dist_q);

endmodule

[sv/sorted_dependency_index_table.sv]
// Top level: sorted dependency index table, controller plus datapath.
// Record: scan for the insert position, shift of the larger entries, one write, then the ack.
// Retire: compacting pass over the entry RAM, then the ack.
// Invalidate: scan with node output, sorted region output, then the flush result.
// One request at a time; final result as busy falls.
// Reset clears counts and control; table words are read only below the entry count.
`timescale 1ns / 1ps
module sorted_dependency_index_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [15:0] dep_id_i,
  input  logic [15:0] node_id_i,
  input  logic [15:0] region_id_i,
  input  logic [15:0] method_id_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [15:0] item_value_o,
  output logic [2:0]  status_o,
  output logic        last_o,
  output logic [5:0]  entry_count_o,
  output logic [5:0]  distinct_deps_o
);

  sdit_pkg::ctrl_cmd_t  cmd;
  sdit_pkg::ctrl_stat_t stat;

  sdit_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .op_i  (op_i),
    .stat_i(stat),
    .cmd_o (cmd),
    .busy_o(busy)
  );

  sdit_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (op_i),
    .dep_id_i       (dep_id_i),
    .node_id_i      (node_id_i),
    .region_id_i    (region_id_i),
    .method_id_i    (method_id_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .item_value_o   (item_value_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .entry_count_o  (entry_count_o),
    .distinct_deps_o(distinct_deps_o)
  );

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == sdit_pkg::KIND_ACK || kind_o == sdit_pkg::KIND_EMPTY))
      |-> last_o) else $error("ack or empty marker without last");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_count_o <= 6'(sdit_pkg::CAPACITY)) && (distinct_deps_o <= entry_count_o))
    else $error("entry or dependency count out of range");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy) else $error("final result while still busy");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the sorted dependency index table.
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] dep;
    logic [15:0] node;
    logic [15:0] region;
    logic [15:0] method;
  } req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [2:0]  status;
    logic        last;
    logic [5:0]  count;
    logic [5:0]  deps;
  } rsp_t;

  typedef struct {
    logic [15:0] dep;
    logic [15:0] node;
    logic [15:0] region;
    logic [15:0] method;
  } ent_t;

  localparam int WATCHDOG = 20000;

  logic        clk_i, rst_ni;
  logic        start, busy;
  logic [1:0]  op_i;
  logic [15:0] dep_id_i, node_id_i, region_id_i, method_id_i;
  logic        result_valid_o;
  logic [1:0]  kind_o;
  logic [15:0] item_value_o;
  logic [2:0]  status_o;
  logic        last_o;
  logic [5:0]  entry_count_o, distinct_deps_o;

  sorted_dependency_index_table dut (.*);

  req_t req_q[$];
  rsp_t expected_q[$];
  ent_t shadow[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   all_sent = 0;
  bit   drain_hold = 0;
  int   gap_left = 0, burst_left = 0;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int key_order(ent_t a, logic [15:0] d, logic [15:0] n, logic [15:0] r);
    if (a.dep != d) return a.dep < d ? -1 : 1;
    if (a.node != n) return a.node < n ? -1 : 1;
    if (a.region != r) return a.region < r ? -1 : 1;
    return 0;
  endfunction

  function automatic logic [5:0] dep_groups();
    int n = 0;
    for (int i = 0; i < shadow.size(); i++)
      if (i == 0 || shadow[i].dep != shadow[i-1].dep) n++;
    return n[5:0];
  endfunction

  function automatic void queue_rsp(logic [1:0] k, logic [15:0] v, logic [2:0] s, logic l);
    rsp_t r;
    r.kind = k; r.value = v; r.status = s; r.last = l;
    r.count = 6'(shadow.size()); r.deps = dep_groups();
    expected_q.insert(expected_q.size(), r);
  endfunction

  // update the table copy and queue the responses one request causes
  function automatic void predict_table(req_t q);
    int pos;
    logic [2:0] st;
    logic [15:0] regs[$];
    logic [15:0] prev;
    bit have;
    int first;
    ent_t e;
    unique case (q.op)
      sdit_pkg::OP_RECORD: begin
        pos = 0;
        if (q.dep == sdit_pkg::INV_ID ||
            (q.node == sdit_pkg::INV_ID && q.region == sdit_pkg::INV_ID))
          st = sdit_pkg::ST_IGNORED;
        else begin
          while (pos < shadow.size() && key_order(shadow[pos], q.dep, q.node, q.region) < 0)
            pos++;
          if (pos < shadow.size() && key_order(shadow[pos], q.dep, q.node, q.region) == 0)
            st = sdit_pkg::ST_DUP;
          else if (shadow.size() >= sdit_pkg::CAPACITY) st = sdit_pkg::ST_FULL;
          else begin
            e.dep = q.dep; e.node = q.node; e.region = q.region; e.method = q.method;
            shadow.insert(pos, e);
            st = sdit_pkg::ST_INSERTED;
          end
        end
        queue_rsp(sdit_pkg::KIND_ACK, 0, st, 1);
      end
      sdit_pkg::OP_INVAL: begin
        first = expected_q.size();
        have = 0;
        if (q.dep != sdit_pkg::INV_ID) begin
          foreach (shadow[i]) if (shadow[i].dep == q.dep) begin
            if (shadow[i].node != sdit_pkg::INV_ID && (!have || shadow[i].node != prev)) begin
              queue_rsp(sdit_pkg::KIND_NODE, shadow[i].node, sdit_pkg::ST_DONE, 0);
              prev = shadow[i].node; have = 1;
            end
            if (shadow[i].region != sdit_pkg::INV_ID)
              regs.insert(regs.size(), shadow[i].region);
          end
          regs.sort();
          foreach (regs[i])
            if (i == 0 || regs[i] != regs[i-1])
              queue_rsp(sdit_pkg::KIND_REGION, regs[i], sdit_pkg::ST_DONE, 0);
        end
        if (expected_q.size() == first)
          queue_rsp(sdit_pkg::KIND_EMPTY, 0, sdit_pkg::ST_DONE, 1);
        else expected_q[$].last = 1;
      end
      sdit_pkg::OP_RETIRE: begin
        for (int i = shadow.size() - 1; i >= 0; i--)
          if (shadow[i].method == q.method) shadow.delete(i);
        queue_rsp(sdit_pkg::KIND_ACK, 0, sdit_pkg::ST_DONE, 1);
      end
      default: queue_rsp(sdit_pkg::KIND_ACK, 0, sdit_pkg::ST_IGNORED, 1);
    endcase
  endfunction

  function automatic void add_req(logic [1:0] o, logic [15:0] d, logic [15:0] n,
                                  logic [15:0] r, logic [15:0] m);
    req_t q;
    q.op = o; q.dep = d; q.node = n; q.region = r; q.method = m;
    req_q.insert(req_q.size(), q);
  endfunction

  // small id pools keep duplicates, shared deps and retire hits frequent
  function automatic logic [15:0] pick_id(int pool);
    unique case ($urandom_range(0, 9))
      0: return sdit_pkg::INV_ID;
      1: return 16'($urandom_range(0, 65535));
      default: return (pool == 0) ? 16'($urandom_range(0, 3))
                                  : 16'(16'hFFF0 + $urandom_range(0, 15));
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 0;
      op_i <= 0; dep_id_i <= 0; node_id_i <= 0; region_id_i <= 0; method_id_i <= 0;
    end else if (start && busy) begin
      // hold request until taken
    end else begin
      if (start) begin
        predict_table('{op_i, dep_id_i, node_id_i, region_id_i, method_id_i});
        if (req_q.size() == 120 || req_q.size() == 40) drain_hold = 1;
      end
      if (drain_hold && expected_q.size() == 0 && !busy) drain_hold = 0;
      if (req_q.size() == 0) begin
        start <= 0;
        if (start) all_sent = 1;
      end else if (drain_hold) begin
        start <= 0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 0;
      end else begin
        automatic req_t q = req_q.pop_front();
        start <= 1;
        op_i <= q.op; dep_id_i <= q.dep; node_id_i <= q.node;
        region_id_i <= q.region; method_id_i <= q.method;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 6);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result kind=%0d value=%0h", kind_o, item_value_o);
          errors++;
        end else begin
          automatic rsp_t x = expected_q.pop_front();
          if (kind_o !== x.kind) begin
            $error("kind: expected %0d, got %0d", x.kind, kind_o); errors++; end
          if (item_value_o !== x.value) begin
            $error("item_value: expected %0h, got %0h", x.value, item_value_o); errors++; end
          if (status_o !== x.status) begin
            $error("status: expected %0d, got %0d", x.status, status_o); errors++; end
          if (last_o !== x.last) begin
            $error("last: expected %0d, got %0d", x.last, last_o); errors++; end
          if (entry_count_o !== x.count) begin
            $error("entry_count: expected %0d, got %0d", x.count, entry_count_o); errors++; end
          if (distinct_deps_o !== x.deps) begin
            $error("distinct_deps: expected %0d, got %0d", x.deps, distinct_deps_o);
            errors++;
          end
        end
      end
      if (result_valid_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("sorted_dependency_index_table: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 0;
    // directed: extremes, invalid ids, duplicates, every op, unused op code
    add_req(sdit_pkg::OP_INVAL, 5, 0, 0, 0);
    add_req(sdit_pkg::OP_RECORD, 16'hFFFF, 1, 1, 1);
    add_req(sdit_pkg::OP_RECORD, 5, 16'hFFFF, 16'hFFFF, 1);
    add_req(sdit_pkg::OP_RECORD, 5, 7, 3, 1);
    add_req(sdit_pkg::OP_RECORD, 5, 7, 3, 2);
    add_req(sdit_pkg::OP_RECORD, 5, 16'hFFFF, 2, 2);
    add_req(sdit_pkg::OP_RECORD, 5, 0, 16'hFFFE, 3);
    add_req(sdit_pkg::OP_RECORD, 0, 16'hFFFE, 16'hFFFF, 16'hFFFF);
    add_req(sdit_pkg::OP_RECORD, 16'hFFFE, 16'h8000, 0, 0);
    add_req(sdit_pkg::OP_RECORD, 5, 7, 2, 3);
    add_req(sdit_pkg::OP_INVAL, 5, 0, 0, 0);
    add_req(sdit_pkg::OP_INVAL, 16'hFFFF, 0, 0, 0);
    add_req(sdit_pkg::OP_INVAL, 9, 0, 0, 0);
    add_req(sdit_pkg::OP_UNUSED, 16'hAAAA, 16'h5555, 16'hFFFF, 0);
    add_req(sdit_pkg::OP_RETIRE, 0, 0, 0, 3);
    add_req(sdit_pkg::OP_INVAL, 5, 0, 0, 0);
    add_req(sdit_pkg::OP_RETIRE, 0, 0, 0, 16'hFFFF);
    add_req(sdit_pkg::OP_RETIRE, 0, 0, 0, 16'h1234);
    // fill past capacity so the full case and a full table invalidate occur
    for (int i = 0; i < 36; i++)
      add_req(sdit_pkg::OP_RECORD, 16'(i % 3), 16'(i), 16'(16'hFFFF - i - 1), 16'(i % 4));
    add_req(sdit_pkg::OP_INVAL, 1, 0, 0, 0);
    for (int m = 0; m < 4; m++) add_req(sdit_pkg::OP_RETIRE, 0, 0, 0, 16'(m));
    for (int i = 0; i < 290; i++) begin
      automatic int sel = $urandom_range(0, 99);
      automatic int pool = $urandom_range(0, 1);
      if (sel < 60)
        add_req(sdit_pkg::OP_RECORD, pick_id(pool), pick_id(pool), pick_id(pool),
                16'($urandom_range(0, 5)));
      else if (sel < 80)
        add_req(sdit_pkg::OP_INVAL, pick_id(pool), 16'($urandom), 16'($urandom),
                16'($urandom));
      else if (sel < 95)
        add_req(sdit_pkg::OP_RETIRE, 16'($urandom), 16'($urandom), 16'($urandom),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5)));
      else
        add_req(sdit_pkg::OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    wait (all_sent && expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0)
      $display("sorted_dependency_index_table: match");
    else
      $display("sorted_dependency_index_table: mismatch");
    $finish;
  end
endmodule

[sim.f]
sv/sdit_pkg.sv
sv/sdit_ram.sv
sv/sdit_ctrl.sv
sv/sdit_dp.sv
sv/sorted_dependency_index_table.sv
tb/sv/tb_top.sv
